// ===== sv/bmsrfp_pkg.sv =====
// bmsrfp_pkg: types, codes and constants of the battery management response frame parser
// no dependencies; imported by bmsrfp_core and bms_response_frame_parser
`timescale 1ns / 1ps

package bmsrfp_pkg;

    // parser phases, one-hot
    typedef enum logic [13:0] {
        PH_HUNT    = 14'b00000000000001,
        PH_REG     = 14'b00000000000010,
        PH_STATUS  = 14'b00000000000100,
        PH_LEN     = 14'b00000000001000,
        PH_WORD_HI = 14'b00000000010000,
        PH_WORD_LO = 14'b00000000100000,
        PH_IBYTE   = 14'b00000001000000,
        PH_TEMP_HI = 14'b00000010000000,
        PH_TEMP_LO = 14'b00000100000000,
        PH_NAME    = 14'b00001000000000,
        PH_CK_HI   = 14'b00010000000000,
        PH_CK_LO   = 14'b00100000000000,
        PH_END     = 14'b01000000000000,
        PH_SKIP    = 14'b10000000000000
    } phase_t;

    typedef enum logic [1:0] {
        FT_NONE  = 2'd0,
        FT_BASIC = 2'd1,
        FT_CELLS = 2'd2,
        FT_NAME  = 2'd3
    } ftype_t;

    typedef enum logic [2:0] {
        KIND_WORD    = 3'd0,
        KIND_IBYTE   = 3'd1,
        KIND_TEMP    = 3'd2,
        KIND_CELL    = 3'd3,
        KIND_CHAR    = 3'd4,
        KIND_VERDICT = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        V_OK      = 3'd0,
        V_UNKNOWN = 3'd1,
        V_CMDERR  = 3'd2,
        V_CKSUM   = 3'd3,
        V_ENDBAD  = 3'd4,
        V_INCOMP  = 3'd5
    } verdict_t;

    // one result item
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  index;
        logic [15:0] value;
        verdict_t    verdict;
        logic        done;
    } rec_t;

    // configuration register indexes
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    localparam logic [7:0] START_MARKER_RST = 8'hDD;
    localparam logic [7:0] END_MARKER_RST   = 8'h77;

    // register codes of the response
    localparam logic [7:0] CODE_BASIC = 8'h03;
    localparam logic [7:0] CODE_CELLS = 8'h04;
    localparam logic [7:0] CODE_NAME  = 8'h05;

    localparam logic [7:0] STATUS_CMD_ERR = 8'h80;
    localparam logic [7:0] INFO_WORDS     = 8'd9;
    localparam logic [7:0] INFO_BYTES     = 8'd5;

endpackage

// ===== sv/bmsrfp_core.sv =====
// bmsrfp_core: frame state registers and the per-byte decode step
// depends on bmsrfp_pkg
`timescale 1ns / 1ps

module bmsrfp_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          start_marker,
    input  logic [7:0]          end_marker,
    input  logic                step_en,
    input  logic [7:0]          data_byte,
    input  logic                buffer_end,
    output logic                rec_valid,
    output bmsrfp_pkg::rec_t    rec
);
    import bmsrfp_pkg::*;

    phase_t      phase_reg, phase_next;
    ftype_t      ftype_reg, ftype_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  hold_reg, hold_next;
    verdict_t    pend_reg, pend_next;

    always_comb
    begin
        logic        closed;
        logic [15:0] word;
        logic [15:0] sum_add;
        closed     = 1'b0;
        word       = {hold_reg, data_byte};
        sum_add    = sum_reg + {8'd0, data_byte};
        phase_next = phase_reg;
        ftype_next = ftype_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        hold_next  = hold_reg;
        pend_next  = pend_reg;
        rec_valid  = 1'b0;
        rec        = '0;

        case (phase_reg)
            PH_REG:
            begin
                sum_next  = '0;
                cnt_next  = '0;
                pend_next = V_OK;
                if (data_byte == CODE_BASIC)
                begin
                    ftype_next = FT_BASIC;
                    phase_next = PH_STATUS;
                end
                else if (data_byte == CODE_CELLS)
                begin
                    ftype_next = FT_CELLS;
                    phase_next = PH_STATUS;
                end
                else if (data_byte == CODE_NAME)
                begin
                    ftype_next = FT_NAME;
                    phase_next = PH_STATUS;
                end
                else
                begin
                    ftype_next  = FT_NONE;
                    rec_valid   = 1'b1;
                    rec.kind    = KIND_VERDICT;
                    rec.verdict = V_UNKNOWN;
                    rec.done    = 1'b1;
                    closed      = 1'b1;
                    phase_next  = PH_HUNT;
                end
            end
            PH_STATUS:
            begin
                if (ftype_reg == FT_BASIC && data_byte == STATUS_CMD_ERR)
                begin
                    phase_next = PH_SKIP;
                end
                else
                begin
                    sum_next   = sum_add;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                sum_next = sum_add;
                cnt_next = '0;
                if (ftype_reg == FT_BASIC)
                begin
                    left_next  = INFO_WORDS;
                    phase_next = PH_WORD_HI;
                end
                else if (ftype_reg == FT_CELLS)
                begin
                    left_next  = {1'b0, data_byte[7:1]};
                    phase_next = (data_byte[7:1] != 7'd0) ? PH_WORD_HI : PH_CK_HI;
                end
                else
                begin
                    left_next  = data_byte;
                    phase_next = (data_byte != 8'd0) ? PH_NAME : PH_CK_HI;
                end
            end
            PH_WORD_HI, PH_TEMP_HI:
            begin
                sum_next   = sum_add;
                hold_next  = data_byte;
                phase_next = (phase_reg == PH_WORD_HI) ? PH_WORD_LO : PH_TEMP_LO;
            end
            PH_WORD_LO, PH_TEMP_LO:
            begin
                sum_next  = sum_add;
                rec_valid = 1'b1;
                if (phase_reg == PH_TEMP_LO)
                    rec.kind = KIND_TEMP;
                else
                    rec.kind = (ftype_reg == FT_BASIC) ? KIND_WORD : KIND_CELL;
                rec.index = cnt_reg;
                rec.value = word;
                cnt_next  = cnt_reg + 8'd1;
                left_next = left_reg - 8'd1;
                if (left_reg != 8'd1)
                begin
                    phase_next = (phase_reg == PH_WORD_LO) ? PH_WORD_HI : PH_TEMP_HI;
                end
                else if (phase_reg == PH_WORD_LO && ftype_reg == FT_BASIC)
                begin
                    cnt_next   = '0;
                    left_next  = INFO_BYTES;
                    phase_next = PH_IBYTE;
                end
                else
                begin
                    phase_next = PH_CK_HI;
                end
            end
            PH_IBYTE:
            begin
                sum_next  = sum_add;
                rec_valid = 1'b1;
                rec.kind  = KIND_IBYTE;
                rec.index = cnt_reg;
                rec.value = {8'd0, data_byte};
                cnt_next  = cnt_reg + 8'd1;
                left_next = left_reg - 8'd1;
                // last info byte holds the temperature count
                if (left_reg == 8'd1)
                begin
                    cnt_next   = '0;
                    left_next  = data_byte;
                    phase_next = (data_byte != 8'd0) ? PH_TEMP_HI : PH_CK_HI;
                end
            end
            PH_NAME:
            begin
                sum_next  = sum_add;
                rec_valid = 1'b1;
                rec.kind  = KIND_CHAR;
                rec.index = cnt_reg;
                rec.value = {8'd0, data_byte};
                cnt_next  = cnt_reg + 8'd1;
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                    phase_next = PH_CK_HI;
            end
            PH_CK_HI:
            begin
                hold_next  = data_byte;
                phase_next = PH_CK_LO;
            end
            PH_CK_LO:
            begin
                // checksum is the two's complement of the sum
                pend_next  = ((16'd0 - sum_reg) == word) ? V_OK : V_CKSUM;
                phase_next = PH_END;
            end
            PH_END:
            begin
                rec_valid = 1'b1;
                rec.kind  = KIND_VERDICT;
                rec.done  = 1'b1;
                if (pend_reg != V_OK)
                    rec.verdict = pend_reg;
                else
                    rec.verdict = (data_byte == end_marker) ? V_OK : V_ENDBAD;
                closed     = 1'b1;
                pend_next  = V_OK;
                phase_next = PH_HUNT;
            end
            PH_SKIP:
            begin
                if (data_byte == end_marker)
                begin
                    rec_valid   = 1'b1;
                    rec.kind    = KIND_VERDICT;
                    rec.verdict = V_CMDERR;
                    rec.done    = 1'b1;
                    closed      = 1'b1;
                    phase_next  = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = (data_byte == start_marker) ? PH_REG : PH_HUNT;
            end
        endcase

        // buffer ran out with a frame still open
        if (buffer_end && !closed && phase_next != PH_HUNT)
        begin
            rec_valid   = 1'b1;
            rec         = '0;
            rec.kind    = KIND_VERDICT;
            rec.verdict = V_INCOMP;
            rec.done    = 1'b1;
            phase_next  = PH_HUNT;
            pend_next   = V_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            ftype_reg <= FT_NONE;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            left_reg  <= '0;
            hold_reg  <= '0;
            pend_reg  <= V_OK;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            ftype_reg <= ftype_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            hold_reg  <= hold_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// ===== sv/bms_response_frame_parser.sv =====
// Response frame parser for a battery management serial link. Takes one received byte per
// cycle on the slave stream (tlast marks the last byte of a received buffer) and emits one
// record per decoded field, plus a verdict record (tlast high) closing each frame. A byte
// passes an input register, one step of the frame state machine and an output register
// before its record reaches the master side, and with the master side ready a new byte is
// taken every cycle; that rate rests on the state update of the parser, which decodes each
// byte in one step. The user must set start and end marker bytes through the write port
// only while the stream is idle; the block itself does not enforce this.
// top level; depends on bmsrfp_pkg and bmsrfp_core
`timescale 1ns / 1ps

module bms_response_frame_parser
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_data,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // buffer_end
    // record stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] field_index, [23:8] field_value, [26:24] verdict
    output logic [2:0]  m_tuser,   // [2:0] record_kind
    output logic        m_tlast    // frame_done
);
    import bmsrfp_pkg::*;

    logic [7:0] start_reg;
    logic [7:0] end_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic       out_valid_reg;
    rec_t       out_rec_reg;

    logic       step_en;
    logic       rec_valid;
    rec_t       rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_MARKER_RST;
            end_reg   <= END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_START_MARKER: start_reg <= cfg_data;
                REG_END_MARKER:   end_reg   <= cfg_data;
                default:          start_reg <= start_reg;
            endcase
        end
    end

    // staged item moves on when the output register is free or being emptied
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    bmsrfp_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_marker (start_reg),
        .end_marker   (end_reg),
        .step_en      (step_en),
        .data_byte    (in_byte_reg),
        .buffer_end   (in_last_reg),
        .rec_valid    (rec_valid),
        .rec          (rec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en)
            out_valid_reg <= rec_valid;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_en && rec_valid)
            out_rec_reg <= rec;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_rec_reg.verdict, out_rec_reg.value, out_rec_reg.index};
    assign m_tuser  = out_rec_reg.kind;
    assign m_tlast  = out_rec_reg.done;

endmodule
